// File: hw/rtl/phfe_pkg.sv
package phfe_pkg;

    localparam int FIELD_COUNT = 27;
    localparam int IDX_W       = 5;
    localparam int VAL_W       = 48;

    // field groups
    localparam logic [2:0] GRP_COMMON = 3'd0;
    localparam logic [2:0] GRP_TCP    = 3'd1;
    localparam logic [2:0] GRP_UDP    = 3'd2;
    localparam logic [2:0] GRP_OPT    = 3'd3;
    localparam logic [2:0] GRP_NONE   = 3'd4;

    localparam logic [2:0] FIELD_GROUP [FIELD_COUNT] = '{
        GRP_COMMON, GRP_COMMON, GRP_COMMON, GRP_COMMON,
        GRP_COMMON, GRP_COMMON, GRP_COMMON, GRP_COMMON,
        GRP_TCP, GRP_TCP, GRP_TCP, GRP_TCP, GRP_TCP, GRP_TCP, GRP_TCP,
        GRP_OPT, GRP_OPT, GRP_OPT, GRP_NONE,
        GRP_UDP, GRP_UDP, GRP_UDP, GRP_UDP, GRP_UDP, GRP_UDP, GRP_UDP, GRP_UDP
    };
    localparam logic [4:0] FIELD_OFFS [FIELD_COUNT] = '{
        5'd6, 5'd0, 5'd12, 5'd26, 5'd30, 5'd22, 5'd23, 5'd24,
        5'd0, 5'd2, 5'd4, 5'd8, 5'd14, 5'd13, 5'd16,
        5'd0, 5'd0, 5'd0, 5'd0,
        5'd0, 5'd2, 5'd4, 5'd6, 5'd8, 5'd12, 5'd16, 5'd20
    };
    localparam logic [2:0] FIELD_LEN [FIELD_COUNT] = '{
        3'd6, 3'd6, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1, 3'd2,
        3'd2, 3'd2, 3'd4, 3'd4, 3'd1, 3'd1, 3'd2,
        3'd4, 3'd4, 3'd1, 3'd4,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam int FLD_TS_VAL = 15;
    localparam int FLD_TS_ECR = 16;
    localparam int FLD_WSCALE = 17;

    localparam logic [7:0] OPT_END    = 8'd0;
    localparam logic [7:0] OPT_NOP    = 8'd1;
    localparam logic [7:0] OPT_WSCALE = 8'd3;
    localparam logic [7:0] OPT_TS     = 8'd8;

    localparam logic [1:0] ST_TCP      = 2'd0;
    localparam logic [1:0] ST_UDP      = 2'd1;
    localparam logic [1:0] ST_NOT_IPV4 = 2'd2;
    localparam logic [1:0] ST_NO_L4    = 2'd3;

    typedef logic [VAL_W-1:0] t_val_bank [FIELD_COUNT];

    typedef struct packed {
        logic       push;
        logic [1:0] status;
    } t_push;

endpackage

// File: hw/rtl/phfe_front.sv
module phfe_front
    import phfe_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_first_byte,
    input  logic                   i_last_byte,
    input  logic                   i_is_ipv4,
    input  logic                   i_is_tcp,
    input  logic                   i_is_udp,
    input  logic                   i_bank_busy,
    output t_push                  o_push,
    output t_val_bank              o_vals,
    output logic [FIELD_COUNT-1:0] o_pres
);

    localparam int CW = (POSITION_BITS > 9) ? POSITION_BITS : 9;

    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [2:0]               r_class, n_class;
    logic [7:0]               r_l4, n_l4;
    logic [7:0]               r_thb, n_thb;
    logic [7:0]               r_nop, n_nop;
    logic [15:0]              r_okl, n_okl;
    t_val_bank                r_val, n_val;
    logic [FIELD_COUNT-1:0]   r_pres, n_pres;
    logic                     r_pend, n_pend;
    logic                     acc, copy;

    function automatic logic [15:0] f_start_kl(input logic [7:0] b);
        logic [15:0] kl;
        if (b == OPT_END) begin
            kl = 16'h0000;
        end else if (b == OPT_NOP) begin
            kl = 16'h0101;
        end else begin
            kl = {b, 8'h00};
        end
        return kl;
    endfunction

    assign copy    = r_pend && !i_bank_busy;
    assign o_stall = r_pend && i_bank_busy;
    assign acc     = i_valid && !o_stall;

    always_comb begin
        logic [POSITION_BITS-1:0] p;
        logic [CW-1:0]            px, st, rel, l4x, thbx;
        logic [7:0]               p8, orel, kind, olen, b;
        logic [3:0]               ihl;
        logic [2:0]               ln;
        b       = i_data_byte;
        ihl     = '0;
        ln      = '0;
        st      = '0;
        rel     = '0;
        l4x     = '0;
        thbx    = '0;
        kind    = '0;
        olen    = '0;
        orel    = '0;
        n_class = r_class;
        n_l4    = r_l4;
        n_thb   = r_thb;
        n_nop   = r_nop;
        n_okl   = r_okl;
        n_val   = r_val;
        n_pres  = r_pres;
        n_pos   = r_pos;
        p       = r_pos;
        if (acc && i_first_byte) begin
            n_class = {i_is_udp, i_is_tcp, i_is_ipv4};
            n_l4    = 8'd34;
            n_thb   = '0;
            n_nop   = '0;
            n_okl   = '0;
            n_pres  = '0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                n_val[i] = '0;
            end
            p = '0;
        end
        px = CW'(p);
        p8 = px[7:0];
        if (acc && p != '1) begin
            n_pos = p + 1'b1;
            if (px == CW'(14)) begin
                ihl  = b[3:0];
                if (ihl < 4'd5) begin
                    ihl = 4'd5;
                end
                n_l4 = 8'd14 + {2'b00, ihl, 2'b00};
            end
            l4x = CW'(n_l4);
            for (int i = 0; i < FIELD_COUNT; i++) begin
                ln = FIELD_LEN[i];
                st = CW'(FIELD_OFFS[i]);
                if (FIELD_GROUP[i] == GRP_TCP || FIELD_GROUP[i] == GRP_UDP) begin
                    st = st + l4x;
                end
                rel = px - st;
                if ((FIELD_GROUP[i] == GRP_COMMON || FIELD_GROUP[i] == GRP_TCP ||
                     FIELD_GROUP[i] == GRP_UDP) && px >= st && px < st + CW'(ln)) begin
                    if (rel[2:0] == 3'd0) begin
                        n_val[i]  = {40'd0, b};
                        n_pres[i] = 1'b0;
                    end else begin
                        n_val[i]  = {n_val[i][VAL_W-9:0], b};
                    end
                    if (rel[2:0] + 3'd1 == ln) begin
                        n_pres[i] = 1'b1;
                    end
                end
            end
            if (n_class[1]) begin
                if (px == l4x + CW'(12)) begin
                    n_thb = {2'b00, b[7:4], 2'b00};
                end
                thbx = CW'(n_thb);
                if (n_thb > 8'd20 && px >= l4x + CW'(20) && px < l4x + thbx) begin
                    if (px == l4x + CW'(20)) begin
                        n_nop = p8;
                        n_okl = f_start_kl(b);
                    end else if (n_okl != 16'd0) begin
                        kind = n_okl[15:8];
                        olen = n_okl[7:0];
                        orel = p8 - n_nop;
                        if (olen != 8'd0 && orel >= olen) begin
                            n_nop = p8;
                            n_okl = f_start_kl(b);
                        end else if (olen == 8'd0) begin
                            n_okl = (b < 8'd2) ? 16'd0 : {kind, b};
                        end else if (orel >= 8'd2) begin
                            if (kind == OPT_WSCALE && olen >= 8'd3 && orel == 8'd2) begin
                                n_val[FLD_WSCALE]  = {40'd0, b};
                                n_pres[FLD_WSCALE] = 1'b1;
                            end else if (kind == OPT_TS && olen >= 8'd10) begin
                                if (orel <= 8'd5) begin
                                    n_val[FLD_TS_VAL] = (orel == 8'd2) ? {40'd0, b}
                                        : {n_val[FLD_TS_VAL][VAL_W-9:0], b};
                                    n_pres[FLD_TS_VAL] = (orel == 8'd5);
                                end else if (orel <= 8'd9) begin
                                    n_val[FLD_TS_ECR] = (orel == 8'd6) ? {40'd0, b}
                                        : {n_val[FLD_TS_ECR][VAL_W-9:0], b};
                                    n_pres[FLD_TS_ECR] = (orel == 8'd9);
                                end
                            end
                        end
                    end
                end
            end
        end else if (acc) begin
            n_pos = p;
        end
        n_pend = (r_pend && !copy) || (acc && i_last_byte);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_class <= '0;
            r_l4    <= '0;
            r_thb   <= '0;
            r_nop   <= '0;
            r_okl   <= '0;
            r_pres  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_class <= n_class;
            r_l4    <= n_l4;
            r_thb   <= n_thb;
            r_nop   <= n_nop;
            r_okl   <= n_okl;
            r_pres  <= n_pres;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_comb begin
        o_push.push = copy;
        if (!r_class[0]) begin
            o_push.status = ST_NOT_IPV4;
        end else if (r_class[1]) begin
            o_push.status = ST_TCP;
        end else if (r_class[2]) begin
            o_push.status = ST_UDP;
        end else begin
            o_push.status = ST_NO_L4;
        end
    end

    assign o_vals = r_val;
    assign o_pres = r_pres;

    a_stall_only_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_pend) else $error("stall without pending packet");
    a_last_sets_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_last_byte) |=> r_pend) else $error("last byte lost");
    a_copy_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (copy && !(acc && i_last_byte)) |=> !r_pend) else $error("pending not cleared");

endmodule

// File: hw/rtl/phfe_back.sv
module phfe_back
    import phfe_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_push                  i_push,
    input  t_val_bank              i_vals,
    input  logic [FIELD_COUNT-1:0] i_pres,
    output logic                   o_bank_busy,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [1:0]             o_status,
    output logic [IDX_W-1:0]       o_field_index,
    output logic [VAL_W-1:0]       o_field_value,
    output logic                   o_field_present,
    output logic                   o_run_end
);

    t_val_bank              r_val;
    logic [FIELD_COUNT-1:0] r_ok, n_ok;
    logic [1:0]             r_status;
    logic                   r_busy;
    logic [IDX_W-1:0]       r_idx;
    logic                   err, present;

    // presence is qualified by protocol once, when the packet enters the result bank
    always_comb begin
        for (int i = 0; i < FIELD_COUNT; i++) begin
            case (FIELD_GROUP[i])
                GRP_COMMON: n_ok[i] = i_pres[i];
                GRP_TCP, GRP_OPT: n_ok[i] = i_pres[i] && (i_push.status == ST_TCP);
                GRP_UDP: n_ok[i] = i_pres[i] && (i_push.status == ST_UDP);
                default: n_ok[i] = 1'b0;
            endcase
        end
    end

    assign err     = (r_status == ST_NOT_IPV4) || (r_status == ST_NO_L4);
    assign present = !err && r_ok[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_idx    <= '0;
            r_status <= ST_TCP;
            r_ok     <= '0;
        end else if (i_push.push) begin
            r_busy   <= 1'b1;
            r_idx    <= '0;
            r_status <= i_push.status;
            r_ok     <= n_ok;
        end else if (r_busy && !i_stall) begin
            if (o_run_end) begin
                r_busy <= 1'b0;
            end else begin
                r_idx  <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_val <= i_vals;
        end
    end

    assign o_bank_busy     = r_busy;
    assign o_valid         = r_busy;
    assign o_status        = r_status;
    assign o_field_index   = r_idx;
    assign o_field_present = present;
    assign o_field_value   = present ? r_val[r_idx] : '0;
    assign o_run_end       = err || (r_idx == IDX_W'(FIELD_COUNT - 1));

    a_push_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> !r_busy) else $error("push into busy bank");
    a_end_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_run_end) |=> !o_valid) else $error("run did not end");
    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && err) |-> (o_field_index == '0 && !o_field_present))
        else $error("bad error result");

endmodule

// File: hw/rtl/packet_header_field_extractor.sv
// Packet header field extractor: Ethernet / IPv4 / TCP-or-UDP.
// Input channel (i_valid / o_stall): one packet byte per request, with
// first/last markers; the class flags are sampled with the first byte.
// Output channel (o_valid / i_stall): after a packet's last byte, 27 field
// results in table order (or one error result) follow, run_end on the last.
// The byte parser takes one byte per cycle unless stalled. After the last
// byte the captured fields are held pending, then move into a one-packet
// result bank once it is free; the first result shows the cycle after that.
// Results leave at one per cycle while i_stall is low (single read port).
// The parser keeps taking bytes of the next packet while results drain; it
// stalls only when a further packet has ended and the bank is still busy.
// A stalled result holds its value until taken.
// Reset (synchronous, active low) empties the bank and clears parser state;
// bytes arriving without a first byte after reset report "not IPv4".
module packet_header_field_extractor
    import phfe_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_data_byte,
    input  logic             i_first_byte,
    input  logic             i_last_byte,
    input  logic             i_is_ipv4,
    input  logic             i_is_tcp,
    input  logic             i_is_udp,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_status,
    output logic [IDX_W-1:0] o_field_index,
    output logic [VAL_W-1:0] o_field_value,
    output logic             o_field_present,
    output logic             o_run_end
);

    t_push                  push;
    t_val_bank              vals;
    logic [FIELD_COUNT-1:0] pres;
    logic                   bank_busy;

    phfe_front #(
        .POSITION_BITS(POSITION_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_first_byte(i_first_byte),
        .i_last_byte (i_last_byte),
        .i_is_ipv4   (i_is_ipv4),
        .i_is_tcp    (i_is_tcp),
        .i_is_udp    (i_is_udp),
        .i_bank_busy (bank_busy),
        .o_push      (push),
        .o_vals      (vals),
        .o_pres      (pres)
    );

    phfe_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_vals         (vals),
        .i_pres         (pres),
        .o_bank_busy    (bank_busy),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_status       (o_status),
        .o_field_index  (o_field_index),
        .o_field_value  (o_field_value),
        .o_field_present(o_field_present),
        .o_run_end      (o_run_end)
    );

endmodule

// File: test/packet_header_field_extractor_checker.sv
module packet_header_field_extractor_checker
    import phfe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall_in,
    input  logic [7:0]       i_data_byte,
    input  logic             i_first_byte,
    input  logic             i_last_byte,
    input  logic             i_is_ipv4,
    input  logic             i_is_tcp,
    input  logic             i_is_udp,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  logic [1:0]       i_status,
    input  logic [IDX_W-1:0] i_field_index,
    input  logic [VAL_W-1:0] i_field_value,
    input  logic             i_field_present,
    input  logic             i_run_end,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_result_count
);

    typedef struct {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        logic             present;
        logic             run_end;
    } t_field_result;

    t_field_result field_queue[$];

    // parser copy
    logic [15:0]      pos_q;
    logic [2:0]       cls_q;
    logic [7:0]       l4_q;
    logic [7:0]       thl_q;
    logic [7:0]       optpos_q;
    logic [15:0]      optkl_q;
    logic [VAL_W-1:0] vals_q [FIELD_COUNT];
    logic             pres_q [FIELD_COUNT];

    task automatic cap(input int idx, input int rel, input int len, input logic [7:0] b);
        if (rel == 0) begin
            vals_q[idx] = {40'd0, b};
            pres_q[idx] = 1'b0;
        end else begin
            vals_q[idx] = {vals_q[idx][VAL_W-9:0], b};
        end
        if (rel + 1 == len) pres_q[idx] = 1'b1;
    endtask

    task automatic open_option(input int p, input logic [7:0] b);
        optpos_q = p[7:0];
        if (b == OPT_END) optkl_q = 16'd0;
        else if (b == OPT_NOP) optkl_q = 16'h0101;
        else optkl_q = {b, 8'd0};
    endtask

    task automatic walk_option(input int p, input logic [7:0] b);
        int kind;
        int len;
        int rel;
        kind = optkl_q[15:8];
        len = optkl_q[7:0];
        rel = (p - optpos_q) & 16'hFFFF;
        if (len != 0 && rel >= len) begin
            open_option(p, b);
        end else if (len == 0) begin
            if (b < 2) optkl_q = 16'd0;
            else optkl_q = {kind[7:0], b};
        end else if (rel >= 2) begin
            if (kind == OPT_WSCALE && len >= 3 && rel == 2) begin
                cap(FLD_WSCALE, 0, 1, b);
            end else if (kind == OPT_TS && len >= 10) begin
                if (rel <= 5) cap(FLD_TS_VAL, rel - 2, 4, b);
                else if (rel <= 9) cap(FLD_TS_ECR, rel - 6, 4, b);
            end
        end
    endtask

    task automatic parse_byte(input int p, input logic [7:0] b);
        int l4;
        int ihl;
        int st;
        l4 = l4_q;
        if (p == 14) begin
            ihl = b[3:0];
            if (ihl < 5) ihl = 5;
            l4_q = 8'(14 + 4 * ihl);
            l4 = l4_q;
        end
        for (int i = 0; i < FIELD_COUNT; i++) begin
            if (FIELD_GROUP[i] == GRP_COMMON) st = FIELD_OFFS[i];
            else if (FIELD_GROUP[i] == GRP_TCP || FIELD_GROUP[i] == GRP_UDP)
                st = l4 + FIELD_OFFS[i];
            else continue;
            if (p >= st && p < st + FIELD_LEN[i]) cap(i, p - st, FIELD_LEN[i], b);
        end
        if (cls_q[1]) begin
            if (p == l4 + 12) thl_q = {2'b00, b[7:4], 2'b00};
            if (thl_q > 20 && p >= l4 + 20 && p < l4 + thl_q) begin
                if (p == l4 + 20) open_option(p, b);
                else if (optkl_q != 16'd0) walk_option(p, b);
            end
        end
    endtask

    task automatic predict_byte();
        int p;
        logic [1:0] st;
        logic ok;
        t_field_result r;
        if (i_first_byte) begin
            cls_q = {i_is_udp, i_is_tcp, i_is_ipv4};
            l4_q = 8'd34;
            thl_q = 0;
            optpos_q = 0;
            optkl_q = 0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                vals_q[i] = '0;
                pres_q[i] = 1'b0;
            end
            p = 0;
        end else begin
            p = pos_q;
        end
        if (p < 16'hFFFF) begin
            parse_byte(p, i_data_byte);
            pos_q = 16'(p + 1);
        end else begin
            pos_q = 16'hFFFF;
        end
        if (!i_last_byte) return;
        if (!cls_q[0]) st = ST_NOT_IPV4;
        else if (cls_q[1]) st = ST_TCP;
        else if (cls_q[2]) st = ST_UDP;
        else st = ST_NO_L4;
        if (st == ST_NOT_IPV4 || st == ST_NO_L4) begin
            r = '{st, '0, '0, 1'b0, 1'b1};
            field_queue.push_back(r);
            return;
        end
        for (int i = 0; i < FIELD_COUNT; i++) begin
            case (FIELD_GROUP[i])
                GRP_COMMON: ok = 1'b1;
                GRP_TCP, GRP_OPT: ok = (st == ST_TCP);
                GRP_UDP: ok = (st == ST_UDP);
                default: ok = 1'b0;
            endcase
            ok = ok && pres_q[i];
            r.status = st;
            r.index = IDX_W'(i);
            r.value = ok ? vals_q[i] : '0;
            r.present = ok;
            r.run_end = (i == FIELD_COUNT - 1);
            field_queue.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_field_result e;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            pos_q <= 0;
            cls_q <= 0;
            l4_q <= 0;
            thl_q <= 0;
            optpos_q <= 0;
            optkl_q <= 0;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                vals_q[i] <= '0;
                pres_q[i] <= 1'b0;
            end
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_result_count <= o_result_count + 1;
                if (field_queue.size() == 0) begin
                    $error("unexpected result index %0d", i_field_index);
                    errs++;
                end else begin
                    e = field_queue.pop_front();
                    if (e.status !== i_status) begin
                        $error("status exp %0d got %0d", e.status, i_status);
                        errs++;
                    end
                    if (e.index !== i_field_index) begin
                        $error("field_index exp %0d got %0d", e.index, i_field_index);
                        errs++;
                    end
                    if (e.value !== i_field_value) begin
                        $error("field_value exp %h got %h", e.value, i_field_value);
                        errs++;
                    end
                    if (e.present !== i_field_present) begin
                        $error("field_present exp %0d got %0d", e.present, i_field_present);
                        errs++;
                    end
                    if (e.run_end !== i_run_end) begin
                        $error("run_end exp %0d got %0d", e.run_end, i_run_end);
                        errs++;
                    end
                end
            end
            // blocking update of the parser copy; results pushed after the pop
            if (i_valid && !i_stall_in) predict_byte();
        end
        o_fail_count <= o_fail_count + errs;
        o_pending <= field_queue.size();
    end

endmodule

// File: test/packet_header_field_extractor_tb.sv
module packet_header_field_extractor_tb;
    import phfe_pkg::*;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_stall;
    logic [7:0]       i_data_byte;
    logic             i_first_byte;
    logic             i_last_byte;
    logic             i_is_ipv4;
    logic             i_is_tcp;
    logic             i_is_udp;
    logic             o_valid;
    logic             i_stall;
    logic [1:0]       o_status;
    logic [IDX_W-1:0] o_field_index;
    logic [VAL_W-1:0] o_field_value;
    logic             o_field_present;
    logic             o_run_end;

    int fail_count;
    int pending;
    int result_count;
    int bytes_sent;
    int packets_sent;
    int idle_cycles;
    bit sending_done;
    bit hold_off;

    packet_header_field_extractor uut (.*);

    packet_header_field_extractor_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_stall_in(o_stall),
        .i_data_byte(i_data_byte), .i_first_byte(i_first_byte),
        .i_last_byte(i_last_byte), .i_is_ipv4(i_is_ipv4), .i_is_tcp(i_is_tcp),
        .i_is_udp(i_is_udp), .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_status(o_status), .i_field_index(o_field_index),
        .i_field_value(o_field_value), .i_field_present(o_field_present),
        .i_run_end(o_run_end), .o_fail_count(fail_count), .o_pending(pending),
        .o_result_count(result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one request on the byte channel
    task automatic send_byte(input logic [7:0] b, input bit first, input bit last,
                             input logic [2:0] cls);
        int g;
        g = gap_len();
        if (g > 0) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'($urandom);
            {i_first_byte, i_last_byte} <= 2'($urandom);
            {i_is_udp, i_is_tcp, i_is_ipv4} <= 3'($urandom);
            repeat (g) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= b;
        i_first_byte <= first;
        i_last_byte <= last;
        {i_is_udp, i_is_tcp, i_is_ipv4} <= cls;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // builds a packet; mode 0 well formed, 1 random noise
    task automatic send_packet(input logic [2:0] cls, input int ihl, input int doff,
                               input int len, input int mode, input bit with_first);
        logic [7:0] pkt[];
        int l4;
        int p;
        int k;
        pkt = new[len];
        foreach (pkt[i]) pkt[i] = 8'($urandom);
        l4 = 14 + 4 * ((ihl < 5) ? 5 : ihl);
        if (mode == 0) begin
            if (len > 14) pkt[14] = {4'h4, 4'(ihl)};
            if (len > l4 + 12) pkt[l4 + 12] = {4'(doff), 4'($urandom)};
            p = l4 + 20;
            while (p < l4 + 4 * doff && p < len) begin
                k = $urandom_range(0, 9);
                case (k)
                    0: begin pkt[p] = OPT_END; p = p + 1; end
                    1, 2: begin pkt[p] = OPT_NOP; p = p + 1; end
                    3, 4: begin
                        pkt[p] = OPT_WSCALE;
                        if (p + 1 < len) pkt[p + 1] = 8'($urandom_range(0, 5));
                        p = p + 3;
                    end
                    5, 6, 7: begin
                        pkt[p] = OPT_TS;
                        if (p + 1 < len) pkt[p + 1] = $urandom_range(0, 3) == 0 ?
                            8'($urandom_range(0, 12)) : 8'd10;
                        p = p + 10;
                    end
                    default: begin
                        pkt[p] = 8'($urandom_range(2, 255));
                        if (p + 1 < len) pkt[p + 1] = 8'($urandom_range(0, 6));
                        p = p + 4;
                    end
                endcase
            end
        end
        for (int i = 0; i < len; i++)
            send_byte(pkt[i], with_first && i == 0, i == len - 1, cls);
        packets_sent++;
    endtask

    initial begin
        int r;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_first_byte = 1'b0;
        i_last_byte = 1'b0;
        i_is_ipv4 = 1'b0;
        i_is_tcp = 1'b0;
        i_is_udp = 1'b0;
        bytes_sent = 0;
        packets_sent = 0;
        sending_done = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        // directed: headless bytes after reset, error classes, short, both flags
        send_byte(8'hFF, 0, 1, 3'b111);
        send_byte(8'h00, 1, 1, 3'b110);
        send_byte(8'hA5, 1, 1, 3'b001);
        send_packet(3'b011, 5, 5, 20, 0, 1);
        send_packet(3'b111, 3, 15, 90, 0, 1);
        send_packet(3'b101, 15, 5, 80, 0, 1);
        // sender streams on while receiver holds off
        hold_off = 1;
        send_packet(3'b011, 6, 10, 60, 0, 1);
        send_packet(3'b101, 5, 5, 40, 0, 1);
        while (bytes_sent < 320) begin
            r = $urandom_range(0, 9);
            if (r < 7)
                send_packet({$urandom_range(0, 1) == 0, 2'b11} | {2'b00, 1'b1},
                            $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(40, 110), 0, 1);
            else if (r < 8)
                send_packet(3'b101, $urandom_range(0, 15), 5,
                            $urandom_range(20, 90), 0, 1);
            else
                send_packet(3'($urandom), $urandom_range(0, 15), $urandom_range(0, 15),
                            $urandom_range(1, 80), 1, $urandom_range(0, 5) != 0);
        end
        i_valid <= 1'b0;
        sending_done = 1;
    end

    // receiver stall pattern, with one long hold-off
    initial begin
        int g;
        i_stall = 1'b0;
        wait (hold_off);
        @(negedge i_clk);
        i_stall <= 1'b1;
        repeat (600) @(negedge i_clk);
        i_stall <= 1'b0;
        forever begin
            g = gap_len();
            if (g > 0) begin
                i_stall <= 1'b1;
                repeat (g) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
    end

    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= 2000) begin
                $display("timeout");
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        wait (sending_done);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("sent %0d bytes in %0d packets, checked %0d field results",
                 bytes_sent, packets_sent, result_count);
        if (fail_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
